/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a signal keeps its value on the edge after a condition holds.
`define ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) \
		(cond) |=> $stable(sig)) else $error(msg);

`endif

/* hdl/bte_pkg.sv */
`timescale 1ns / 1ps
package bte_pkg;
	localparam int DataW = 32;
	localparam int BaryW = 17;

	typedef enum logic [1:0] {
		KIND_POINT = 2'd0,
		KIND_DU    = 2'd1,
		KIND_DV    = 2'd2,
		KIND_DW    = 2'd3
	} kind_t;

	typedef struct packed {
		logic             mode;
		logic [3:0]       point_index;
		logic [DataW-1:0] point_x;
		logic [DataW-1:0] point_y;
		logic [DataW-1:0] point_z;
		logic [BaryW-1:0] bary_u;
		logic [BaryW-1:0] bary_v;
		logic [BaryW-1:0] bary_w;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [DataW-1:0] out_x;
		logic [DataW-1:0] out_y;
		logic [DataW-1:0] out_z;
		logic             last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_CUT,
		ST_FINAL,
		ST_DERIV,
		ST_EMIT
	} state_t;
endpackage

/* hdl/bte_if.sv */
`timescale 1ns / 1ps
interface bte_in_if;
	logic valid;
	logic ready;
	bte_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bte_out_if;
	logic valid;
	logic ready;
	bte_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/bezier_triangle_eval.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload
// in_ch     in   mode, point_index, point_x/y/z, bary_u/v/w
// out_ch    out  result_kind, out_x/y/z, last
// cfg       in   degree (cfg_we, cfg_wdata)
// An evaluation reads one operand, then accumulates its product on a single shared
// multiplier for each of the three products of a corner cut. Per coordinate it copies
// the points, runs the cuts, the final cut and the derivatives; then four result beats.
// in_ch.ready is low from acceptance of an evaluate beat until its last result leaves,
// and each result beat waits for out_ch.ready. arst_n resets the sequencer and sets
// degree to 3; control points are not cleared.
module bezier_triangle_eval #(
	parameter int MAX_DEGREE  = 3,
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_wdata,
	bte_in_if.sink           in_ch,
	bte_out_if.source        out_ch
);
	import bte_pkg::*;
	`include "assert_macros.svh"

	localparam int NumPts = (MAX_DEGREE + 1) * (MAX_DEGREE + 2) / 2;
	localparam int IdxW   = $clog2(NumPts);
	localparam int CW     = COORD_WIDTH;
	localparam int PW     = CW + BaryW + 1;   // signed product width
	localparam int AW     = PW + 3;           // accumulator width
	localparam int DegW   = $clog2(NumPts + 1);

	state_t state_q, state_d;
	logic [1:0]      degree_q;
	logic [CW*3-1:0] cp_mem [NumPts];
	logic [CW-1:0]   buf_mem [NumPts];
	logic [CW-1:0]   rd_q;
	logic [BaryW-1:0] u_q, v_q, w_q;
	logic [1:0]      coord_q;
	logic [DegW-1:0] n_q, m_q, r_q, k_q;
	logic [IdxW-1:0] idx_q;
	logic [1:0]      term_q, dcnt_q;
	logic            rd_ok_q;
	logic signed [AW-1:0] acc_q;
	logic [CW-1:0]   res_q [4][3];
	logic [1:0]      kind_q;

	// Effective degree from the register.
	logic [DegW-1:0] n_eff;
	always_comb begin
		n_eff = (degree_q == 2'd0) ? DegW'(1) : DegW'(degree_q);
		if (n_eff > DegW'(MAX_DEGREE)) n_eff = DegW'(MAX_DEGREE);
	end

	function automatic logic [DegW-1:0] tri_base(input logic [DegW-1:0] r);
		logic [2*DegW-1:0] p;
		p = (2*DegW)'(r) * (2*DegW)'(r + DegW'(1));
		return DegW'(p >> 1);
	endfunction

	function automatic logic [CW-1:0] sat_cw(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] hi, lo;
		hi = AW'((64'sd1 <<< (CW - 1)) - 1);
		lo = -hi - AW'(1);
		if (x > hi) return CW'(hi);
		if (x < lo) return CW'(lo);
		return CW'(x);
	endfunction

	function automatic logic [DataW-1:0] sat32(input logic [CW-1:0] x);
		logic signed [AW-1:0] s;
		s = AW'($signed(x));
		if (s > AW'(64'sd2147483647)) return 32'h7fffffff;
		if (s < -AW'(64'sd2147483648)) return 32'h80000000;
		return DataW'(s);
	endfunction

	// Read address for the current cut term.
	logic [DegW-1:0] base_r, nbase_r;
	logic [IdxW-1:0] rd_addr;
	logic [BaryW-1:0] wgt;
	always_comb begin
		base_r  = tri_base(r_q);
		nbase_r = tri_base(r_q + DegW'(1));
		rd_addr = '0;
		wgt     = u_q;
		unique case (term_q)
			2'd0: begin rd_addr = IdxW'(base_r + k_q); wgt = u_q; end
			2'd1: begin rd_addr = IdxW'(nbase_r + k_q); wgt = v_q; end
			2'd2: begin rd_addr = IdxW'(nbase_r + k_q + DegW'(1)); wgt = w_q; end
			default: begin rd_addr = IdxW'(base_r + k_q); wgt = u_q; end
		endcase
		if (state_q == ST_COPY) rd_addr = idx_q;
		if (state_q == ST_DERIV) rd_addr = IdxW'(dcnt_q);
	end

	// Shared multiplier on the registered operand.
	logic signed [PW-1:0] prod;
	assign prod = PW'($signed(rd_q)) * $signed({1'b0, wgt});

	logic signed [AW-1:0] acc_sum, rounded, dprod;
	assign acc_sum = acc_q + AW'(prod);
	assign rounded = (acc_sum + AW'(64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign dprod   = AW'($signed(rd_q)) * $signed({1'b0, n_q});

	logic [CW-1:0] cut_val;
	assign cut_val = sat_cw(rounded);

	logic term_done, row_last, lvl_last;
	assign term_done = rd_ok_q && (term_q == 2'd2);
	assign row_last  = (k_q == r_q) && (r_q + DegW'(1) == m_q);
	assign lvl_last  = (m_q == DegW'(2));

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_EMIT);
	assign out_ch.data.result_kind = kind_q;
	assign out_ch.data.out_x = sat32(res_q[kind_q][0]);
	assign out_ch.data.out_y = sat32(res_q[kind_q][1]);
	assign out_ch.data.out_z = sat32(res_q[kind_q][2]);
	assign out_ch.data.last  = (kind_q == KIND_DW);

	logic accept;
	assign accept = in_ch.valid && in_ch.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && in_ch.data.mode) state_d = ST_COPY;
			ST_COPY:  if (rd_ok_q && idx_q == {IdxW{1'b1}}) begin
				state_d = (n_q == DegW'(1)) ? ST_FINAL : ST_CUT;
			end
			ST_CUT:   if (term_done && row_last && lvl_last) state_d = ST_FINAL;
			ST_FINAL: if (term_done) state_d = ST_DERIV;
			ST_DERIV: if (rd_ok_q && dcnt_q == 2'd0) begin
				state_d = (coord_q == 2'd2) ? ST_EMIT : ST_COPY;
			end
			ST_EMIT:  if (out_ch.ready && kind_q == KIND_DW) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			degree_q <= 2'd3;
		end else begin
			state_q <= state_d;
			if (cfg_we) degree_q <= cfg_wdata;
		end
	end

	// Copy sweeps downward from the last point and wraps the index once more, so the
	// read of slot 0 lands in the cycle after; derivatives read slots 2, 1, 0.
	always_ff @(posedge clk) begin
		if (state_q == ST_COPY) rd_q <= cp_mem[idx_q][CW*coord_q +: CW];
		else rd_q <= buf_mem[rd_addr];
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !in_ch.data.mode && 32'(in_ch.data.point_index) < NumPts) begin
					cp_mem[IdxW'(in_ch.data.point_index)] <= {
						CW'($signed(in_ch.data.point_z)),
						CW'($signed(in_ch.data.point_y)),
						CW'($signed(in_ch.data.point_x))};
				end
				u_q <= in_ch.data.bary_u;
				v_q <= in_ch.data.bary_v;
				w_q <= in_ch.data.bary_w;
				n_q <= n_eff;
				m_q <= n_eff;
				coord_q <= 2'd0;
				idx_q <= IdxW'(tri_base(n_eff + DegW'(1)) - DegW'(1));
				rd_ok_q <= 1'b0;
				kind_q <= KIND_POINT;
			end
			ST_COPY: begin
				idx_q <= idx_q - IdxW'(1);
				if (rd_ok_q) buf_mem[idx_q + IdxW'(1)] <= rd_q;
				if (rd_ok_q && idx_q == {IdxW{1'b1}}) begin
					rd_ok_q <= 1'b0;
					r_q <= '0; k_q <= '0; term_q <= 2'd0; acc_q <= '0;
					m_q <= n_q;
				end else begin
					rd_ok_q <= 1'b1;
				end
			end
			ST_CUT, ST_FINAL: begin
				rd_ok_q <= ~rd_ok_q;
				if (term_done) begin
					acc_q <= '0;
					term_q <= 2'd0;
					if (state_q == ST_CUT) begin
						buf_mem[IdxW'(base_r + k_q)] <= cut_val;
						if (k_q != r_q) k_q <= k_q + DegW'(1);
						else begin
							k_q <= '0;
							if (r_q + DegW'(1) != m_q) r_q <= r_q + DegW'(1);
							else begin
								r_q <= '0;
								m_q <= m_q - DegW'(1);
							end
						end
					end else begin
						res_q[0][coord_q] <= cut_val;
						dcnt_q <= 2'd2;
					end
				end else if (rd_ok_q) begin
					acc_q <= acc_sum;
					term_q <= term_q + 2'd1;
				end
			end
			ST_DERIV: begin
				rd_ok_q <= ~rd_ok_q;
				if (rd_ok_q) begin
					res_q[dcnt_q + 2'd1][coord_q] <= sat_cw(dprod);
					if (dcnt_q != 2'd0) dcnt_q <= dcnt_q - 2'd1;
					else begin
						coord_q <= coord_q + 2'd1;
						idx_q <= IdxW'(tri_base(n_q + DegW'(1)) - DegW'(1));
					end
				end
			end
			ST_EMIT: if (out_ch.ready) kind_q <= kind_q + 2'd1;
			default: ;
		endcase
	end

	`ASSERT_CLK(a_busy_not_ready, clk, arst_n,
		(state_q != ST_IDLE) |-> !in_ch.ready, "ready while busy")
	`ASSERT_CLK(a_out_only_emit, clk, arst_n,
		out_ch.valid |-> (state_q == ST_EMIT), "result outside emit")
	`ASSERT_CLK(a_kind_steps, clk, arst_n,
		(out_ch.valid && out_ch.ready && kind_q != KIND_DW) |=> (kind_q == $past(kind_q) + 2'd1),
		"result kind skipped")
	`ASSERT_HOLD(a_out_stable, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.data,
		"result changed while stalled")
endmodule

/* bench/tb_bezier_triangle_eval.sv */
`timescale 1ns / 1ps
module tb_bezier_triangle_eval;
	import bte_pkg::*;

	localparam int SLOTS = 10;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_wdata;

	bte_in_if in_ch ();
	bte_out_if out_ch ();

	bezier_triangle_eval u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	// Predictor state: control point store and patch degree.
	longint pts [SLOTS][3];
	logic [1:0] deg_reg;

	in_item_t pending_beats[$];
	out_item_t expected_results[$];
	bit failed;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Exact weighted sum with round half up at 16 fraction bits.
	function automatic longint cut(longint a, longint b, longint c,
			longint u, longint v, longint w);
		longint ah, bh, ch, al, bl, cl, hi, lo;
		al = a & 64'hFFFF;
		bl = b & 64'hFFFF;
		cl = c & 64'hFFFF;
		ah = (a - al) >>> 16;
		bh = (b - bl) >>> 16;
		ch = (c - cl) >>> 16;
		hi = ah * u + bh * v + ch * w;
		lo = al * u + bl * v + cl * w + 64'd32768;
		return sat32(hi + (lo >>> 16));
	endfunction

	task automatic predict_evaluation(in_item_t it);
		longint buf_c [SLOTS];
		longint res [4][3];
		longint u, v, w;
		int n, cnt, base, nbase;
		out_item_t o;
		u = it.bary_u;
		v = it.bary_v;
		w = it.bary_w;
		n = (deg_reg == 2'd0) ? 1 : deg_reg;
		cnt = (n + 1) * (n + 2) / 2;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < cnt; k++) buf_c[k] = pts[k][c];
			for (int m = n; m > 1; m--) begin
				for (int r = 0; r < m; r++) begin
					base = r * (r + 1) / 2;
					nbase = (r + 1) * (r + 2) / 2;
					for (int k = 0; k <= r; k++)
						buf_c[base + k] = cut(buf_c[base + k], buf_c[nbase + k],
							buf_c[nbase + k + 1], u, v, w);
				end
			end
			res[0][c] = cut(buf_c[0], buf_c[1], buf_c[2], u, v, w);
			for (int k = 0; k < 3; k++) res[k + 1][c] = sat32(buf_c[k] * n);
		end
		for (int kd = 0; kd < 4; kd++) begin
			o.result_kind = kind_t'(kd);
			o.out_x = res[kd][0][31:0];
			o.out_y = res[kd][1][31:0];
			o.out_z = res[kd][2][31:0];
			o.last = (kd == 3);
			expected_results = {expected_results, o};
		end
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sample acceptance at the rising edge; the driver acts on it at the falling edge.
	bit in_acc;
	always @(posedge clk) in_acc <= arst_n && in_ch.valid && in_ch.ready;

	// Driver: presents queued beats, updates the predictor on acceptance.
	int in_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_acc) begin
				if (in_ch.data.mode == 1'b0) begin
					if (in_ch.data.point_index < SLOTS) begin
						pts[in_ch.data.point_index][0] = longint'(signed'(in_ch.data.point_x));
						pts[in_ch.data.point_index][1] = longint'(signed'(in_ch.data.point_y));
						pts[in_ch.data.point_index][2] = longint'(signed'(in_ch.data.point_z));
					end
				end else begin
					predict_evaluation(in_ch.data);
				end
				void'(pending_beats.pop_front());
				in_gap = gap_len();
			end
			if (!in_ch.valid || in_acc) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pending_beats[0];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	int out_gap;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0) out_gap = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, out_ch.data);
				failed = 1'b1;
			end else begin
				exp_r = expected_results.pop_front();
				if (out_ch.data.result_kind !== exp_r.result_kind ||
						out_ch.data.out_x !== exp_r.out_x ||
						out_ch.data.out_y !== exp_r.out_y ||
						out_ch.data.out_z !== exp_r.out_z ||
						out_ch.data.last !== exp_r.last) begin
					$display("%0t: mismatch expected %p actual %p", $time, exp_r, out_ch.data);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom;
			default: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
		endcase
	endfunction

	function automatic in_item_t load_beat(int slot, logic [31:0] x, logic [31:0] y,
			logic [31:0] z);
		in_item_t it;
		it.mode = 1'b0;
		it.point_index = 4'(slot);
		it.point_x = x;
		it.point_y = y;
		it.point_z = z;
		it.bary_u = 17'($urandom);
		it.bary_v = 17'($urandom);
		it.bary_w = 17'($urandom);
		return it;
	endfunction

	function automatic in_item_t eval_beat(int u, int v, int w);
		in_item_t it;
		it = load_beat(0, $urandom, $urandom, $urandom);
		it.mode = 1'b1;
		it.point_index = 4'($urandom);
		it.bary_u = 17'(u);
		it.bary_v = 17'(v);
		it.bary_w = 17'(w);
		return it;
	endfunction

	function automatic in_item_t rand_eval();
		int u, v;
		if ($urandom_range(0, 4) == 0)
			return eval_beat($urandom_range(0, 131071), $urandom_range(0, 131071),
				$urandom_range(0, 131071));
		u = $urandom_range(0, 65536);
		v = $urandom_range(0, 65536 - u);
		return eval_beat(u, v, 65536 - u - v);
	endfunction

	task automatic drain_and_set(logic [1:0] d);
		while (pending_beats.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		@(negedge clk);
		cfg_wdata <= d;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		deg_reg = d;
	endtask

	initial begin
		logic [1:0] deg_seq [6];
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 2'd0;
		in_gap = 0;
		out_gap = 0;
		failed = 1'b0;
		deg_reg = 2'd3;
		for (int s = 0; s < SLOTS; s++) for (int c = 0; c < 3; c++) pts[s][c] = 0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: fill every slot, extremes, edge weights, ignored slot loads.
		for (int s = 0; s < SLOTS; s++)
			pending_beats = {pending_beats, load_beat(s, (s % 2) ? 32'h7FFFFFFF : 32'h80000000,
				(s % 3) ? 32'h00010000 : 32'hFFFF0000, $urandom)};
		pending_beats = {pending_beats, load_beat(10, 32'h12345678, 32'h0, 32'h0)};
		pending_beats = {pending_beats, load_beat(15, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF)};
		pending_beats = {pending_beats, eval_beat(65536, 0, 0)};
		pending_beats = {pending_beats, eval_beat(0, 65536, 0)};
		pending_beats = {pending_beats, eval_beat(0, 0, 65536)};
		pending_beats = {pending_beats, eval_beat(131071, 131071, 131071)};
		pending_beats = {pending_beats, eval_beat(0, 0, 0)};
		pending_beats = {pending_beats, eval_beat(21845, 21845, 21846)};
		pending_beats = {pending_beats, eval_beat(32768, 32768, 0)};

		deg_seq = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd1, 2'd3};
		foreach (deg_seq[p]) begin
			drain_and_set(deg_seq[p]);
			repeat (32) begin
				if ($urandom_range(0, 2) == 0)
					pending_beats = {pending_beats, load_beat($urandom_range(0, 15),
						rand_coord(), rand_coord(), rand_coord())};
				else
					pending_beats = {pending_beats, rand_eval()};
			end
		end
		while (pending_beats.size() > 0 || expected_results.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (!failed) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("CHECK FAILED");
		$finish;
	end
endmodule

/* files.f */
+incdir+hdl
hdl/bte_pkg.sv
hdl/bte_if.sv
hdl/bezier_triangle_eval.sv
bench/tb_bezier_triangle_eval.sv
